FILE: src/sanns_pkg.sv
// Shared types and constants for the sorted anchor nearest search block.
package sanns_pkg;

  // Width of a coordinate field.
  localparam int unsigned POS_W = 31;

  // Operation codes carried by the input channel.
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  // Search sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_PROBE,
    S_LOW,
    S_UP,
    S_DECIDE,
    S_RESULT
  } srch_state_t;

endpackage

FILE: src/sorted_anchor_nearest_search.sv
// Top level of the sorted anchor nearest search: table memory, search sequencer, result register.
// A load or a clear is taken while the sequencer is idle; a query runs the start, probe,
// low, up and decide states as needed, one memory probe per step, before its result is
// offered on the output. One item at a time: no new item is taken until the last query's
// result has passed to the output register. Reset is synchronous and active low: it empties
// the table (entry count to zero) and the output register; the table contents are not cleared.
module sorted_anchor_nearest_search
  import sanns_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 4096,
  parameter int unsigned TAG_BITS    = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_op,
  input  logic [POS_W-1:0]    in_anchor_query_pos,
  input  logic [POS_W-1:0]    in_anchor_target_pos,
  input  logic [TAG_BITS-1:0] in_anchor_tag,
  input  logic [POS_W-1:0]    in_range_start,
  input  logic [POS_W-1:0]    in_range_end,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_hit,
  output logic [POS_W-1:0]    out_hit_query_pos,
  output logic [POS_W-1:0]    out_hit_target_pos,
  output logic [TAG_BITS-1:0] out_hit_tag
);

  // An entry is stored as {key, partner, tag} in one memory word.
  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned ENT_W = 2 * POS_W + TAG_BITS;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [ENT_W-1:0] wr_data;
  logic [IDX_W-1:0] rd_addr;
  logic [ENT_W-1:0] rd_data;
  logic             res_valid;
  logic             res_ready;
  logic             res_hit;
  logic [ENT_W-1:0] res_entry;

  logic                out_valid_r, out_valid_nxt;
  logic                out_hit_r, out_hit_nxt;
  logic [POS_W-1:0]    out_qpos_r, out_qpos_nxt;
  logic [POS_W-1:0]    out_tpos_r, out_tpos_nxt;
  logic [TAG_BITS-1:0] out_tag_r, out_tag_nxt;

  sanns_table #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W),
    .ENT_W (ENT_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sanns_search #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TAG_BITS    (TAG_BITS),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W),
    .ENT_W       (ENT_W)
  ) u_search (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_op                (in_op),
    .in_anchor_query_pos  (in_anchor_query_pos),
    .in_anchor_target_pos (in_anchor_target_pos),
    .in_anchor_tag        (in_anchor_tag),
    .in_range_start       (in_range_start),
    .in_range_end         (in_range_end),
    .wr_en                (wr_en),
    .wr_addr              (wr_addr),
    .wr_data              (wr_data),
    .rd_addr              (rd_addr),
    .rd_data              (rd_data),
    .res_valid            (res_valid),
    .res_ready            (res_ready),
    .res_hit              (res_hit),
    .res_entry            (res_entry)
  );

  // The output register takes a new result whenever it is empty or its
  // current result is being transferred, so the sequencer can hand over the
  // next result in the same cycle as the previous one leaves.
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_hit_nxt   = out_hit_r;
    out_qpos_nxt  = out_qpos_r;
    out_tpos_nxt  = out_tpos_r;
    out_tag_nxt   = out_tag_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_hit_nxt   = res_hit;
      // A miss reports every field as zero.
      if (res_hit) begin
        out_qpos_nxt = res_entry[ENT_W-1 -: POS_W];
        out_tpos_nxt = res_entry[TAG_BITS +: POS_W];
        out_tag_nxt  = res_entry[TAG_BITS-1:0];
      end else begin
        out_qpos_nxt = '0;
        out_tpos_nxt = '0;
        out_tag_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r  <= out_hit_nxt;
    out_qpos_r <= out_qpos_nxt;
    out_tpos_r <= out_tpos_nxt;
    out_tag_r  <= out_tag_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_hit            = out_hit_r;
  assign out_hit_query_pos  = out_qpos_r;
  assign out_hit_target_pos = out_tpos_r;
  assign out_hit_tag        = out_tag_r;

endmodule

FILE: src/sanns_table.sv
// Anchor table memory: one write port, one read port with registered read data.
module sanns_table #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned IDX_W = 12,
  parameter int unsigned ENT_W = 78
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [ENT_W-1:0] wr_data,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [ENT_W-1:0] rd_data
);

  logic [ENT_W-1:0] mem [DEPTH];
  logic [ENT_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/sanns_search.sv
// Search sequencer: entry count, loads, clears and the binary search over the table.
module sanns_search
  import sanns_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 4096,
  parameter int unsigned TAG_BITS    = 16,
  parameter int unsigned IDX_W       = 12,
  parameter int unsigned CNT_W       = 13,
  parameter int unsigned ENT_W       = 78
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_op,
  input  logic [POS_W-1:0]    in_anchor_query_pos,
  input  logic [POS_W-1:0]    in_anchor_target_pos,
  input  logic [TAG_BITS-1:0] in_anchor_tag,
  input  logic [POS_W-1:0]    in_range_start,
  input  logic [POS_W-1:0]    in_range_end,
  output logic                wr_en,
  output logic [IDX_W-1:0]    wr_addr,
  output logic [ENT_W-1:0]    wr_data,
  output logic [IDX_W-1:0]    rd_addr,
  input  logic [ENT_W-1:0]    rd_data,
  output logic                res_valid,
  input  logic                res_ready,
  output logic                res_hit,
  output logic [ENT_W-1:0]    res_entry
);

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  srch_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] lower_r, lower_nxt;
  logic [CNT_W-1:0] upper_r, upper_nxt;
  logic [CNT_W-1:0] probe_r, probe_nxt;
  logic [POS_W-1:0] mid_r, mid_nxt;
  logic [POS_W-1:0] start_r, start_nxt;
  logic [POS_W-1:0] end_r, end_nxt;
  logic [ENT_W-1:0] lo_ent_r, lo_ent_nxt;
  logic [ENT_W-1:0] up_ent_r, up_ent_nxt;
  logic             lo_in_r, lo_in_nxt;
  logic             up_in_r, up_in_nxt;
  logic [POS_W-1:0] dist_lo_r, dist_lo_nxt;
  logic [POS_W-1:0] dist_up_r, dist_up_nxt;
  logic             res_hit_r, res_hit_nxt;
  logic [ENT_W-1:0] res_ent_r, res_ent_nxt;

  logic [POS_W-1:0] key_rd;
  logic [POS_W:0]   range_sum;
  logic [CNT_W-1:0] step_lo, step_up, step_x;
  logic             step_cont;

  function automatic logic in_range(input logic [POS_W-1:0] k, input logic [POS_W-1:0] s,
                                    input logic [POS_W-1:0] e);
    in_range = (s < k) && (k < e);
  endfunction

  function automatic logic [POS_W-1:0] abs_diff(input logic [POS_W-1:0] a,
                                                input logic [POS_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  assign key_rd    = rd_data[ENT_W-1 -: POS_W];
  assign range_sum = {1'b0, in_range_start} + {1'b0, in_range_end};

  // Bounds for the next probe: straight from the registers when starting, or
  // narrowed by the key just read while probing.
  always_comb begin
    step_lo = lower_r;
    step_up = upper_r;
    if (state_r == S_PROBE) begin
      if (key_rd < mid_r) begin
        step_lo = probe_r;
      end else begin
        step_up = probe_r;
      end
    end
    step_cont = ({1'b0, step_lo} + (CNT_W + 1)'(1)) < {1'b0, step_up};
    step_x    = step_lo + ((step_up - step_lo) >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lower_r   <= lower_nxt;
    upper_r   <= upper_nxt;
    probe_r   <= probe_nxt;
    mid_r     <= mid_nxt;
    start_r   <= start_nxt;
    end_r     <= end_nxt;
    lo_ent_r  <= lo_ent_nxt;
    up_ent_r  <= up_ent_nxt;
    lo_in_r   <= lo_in_nxt;
    up_in_r   <= up_in_nxt;
    dist_lo_r <= dist_lo_nxt;
    dist_up_r <= dist_up_nxt;
    res_hit_r <= res_hit_nxt;
    res_ent_r <= res_ent_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    lower_nxt   = lower_r;
    upper_nxt   = upper_r;
    probe_nxt   = probe_r;
    mid_nxt     = mid_r;
    start_nxt   = start_r;
    end_nxt     = end_r;
    lo_ent_nxt  = lo_ent_r;
    up_ent_nxt  = up_ent_r;
    lo_in_nxt   = lo_in_r;
    up_in_nxt   = up_in_r;
    dist_lo_nxt = dist_lo_r;
    dist_up_nxt = dist_up_r;
    res_hit_nxt = res_hit_r;
    res_ent_nxt = res_ent_r;

    in_ready  = (state_r == S_IDLE);
    res_valid = (state_r == S_RESULT);
    wr_en     = 1'b0;
    wr_addr   = count_r[IDX_W-1:0];
    wr_data   = {in_anchor_query_pos, in_anchor_target_pos, in_anchor_tag};
    rd_addr   = lower_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (op_t'(in_op))
            OP_LOAD: begin
              if (count_r < DEPTH_C) begin
                wr_en     = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            OP_CLEAR: begin
              count_nxt = '0;
            end
            OP_QUERY: begin
              start_nxt = in_range_start;
              end_nxt   = in_range_end;
              mid_nxt   = range_sum[POS_W:1];
              lower_nxt = '0;
              upper_nxt = count_r;
              state_nxt = S_START;
            end
            default: begin
            end
          endcase
        end
      end
      S_START: begin
        if (count_r == '0) begin
          res_hit_nxt = 1'b0;
          state_nxt   = S_RESULT;
        end else if (step_cont) begin
          rd_addr   = step_x[IDX_W-1:0];
          probe_nxt = step_x;
          state_nxt = S_PROBE;
        end else begin
          state_nxt = S_LOW;
        end
      end
      S_PROBE: begin
        if (key_rd == mid_r) begin
          res_hit_nxt = 1'b1;
          res_ent_nxt = rd_data;
          state_nxt   = S_RESULT;
        end else begin
          lower_nxt = step_lo;
          upper_nxt = step_up;
          if (step_cont) begin
            rd_addr   = step_x[IDX_W-1:0];
            probe_nxt = step_x;
          end else begin
            rd_addr   = step_lo[IDX_W-1:0];
            state_nxt = S_LOW;
          end
        end
      end
      S_LOW: begin
        lo_ent_nxt  = rd_data;
        lo_in_nxt   = in_range(key_rd, start_r, end_r);
        dist_lo_nxt = abs_diff(mid_r, key_rd);
        if (key_rd == mid_r) begin
          res_hit_nxt = 1'b1;
          res_ent_nxt = rd_data;
          state_nxt   = S_RESULT;
        end else if (upper_r < count_r) begin
          rd_addr   = upper_r[IDX_W-1:0];
          state_nxt = S_UP;
        end else begin
          res_hit_nxt = in_range(key_rd, start_r, end_r);
          res_ent_nxt = rd_data;
          state_nxt   = S_RESULT;
        end
      end
      S_UP: begin
        up_ent_nxt  = rd_data;
        up_in_nxt   = in_range(key_rd, start_r, end_r);
        dist_up_nxt = abs_diff(mid_r, key_rd);
        state_nxt   = S_DECIDE;
      end
      S_DECIDE: begin
        res_hit_nxt = lo_in_r || up_in_r;
        res_ent_nxt = (dist_lo_r < dist_up_r) ? lo_ent_r : up_ent_r;
        state_nxt   = S_RESULT;
      end
      S_RESULT: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res_hit   = res_hit_r;
  assign res_entry = res_ent_r;

endmodule

FILE: src/sanns_checker.sv
// Port-level checker for the sorted anchor nearest search, bound to the top level.
module sanns_checker
  import sanns_pkg::*;
#(
  parameter int unsigned TAG_BITS = 16
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic [1:0]          in_op,
  input logic                out_valid,
  input logic                out_ready,
  input logic                out_hit,
  input logic [POS_W-1:0]    out_hit_query_pos,
  input logic [POS_W-1:0]    out_hit_target_pos,
  input logic [TAG_BITS-1:0] out_hit_tag
);

  // A result waiting for its transfer stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_hit) && $stable(out_hit_query_pos)
      && $stable(out_hit_target_pos) && $stable(out_hit_tag))
    else $error("result payload changed while stalled");

  // A miss carries all-zero fields.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_hit_query_pos == '0 && out_hit_target_pos == '0
      && out_hit_tag == '0)
    else $error("miss with non-zero fields");

  // A query occupies the search, so no item is taken in the cycle after it.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op == OP_QUERY |=> !in_ready)
    else $error("item accepted while a query is searching");

  // Reset leaves no result on offer.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind sorted_anchor_nearest_search sanns_checker #(.TAG_BITS(TAG_BITS)) u_sanns_checker (.*);
